/* src/csseq_pkg.sv */
// ----------------------------------------------------------------------------
// Crimp station sequencer package
// Shared widths, state codes, command and register codes, and record types.
// ----------------------------------------------------------------------------
package csseq_pkg;

  localparam int unsigned StateW   = 4;
  localparam int unsigned CntW     = 17;
  localparam int unsigned DelayW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CntW-1:0] CntMax = '1;

  // Sequencer state codes
  localparam logic [StateW-1:0] ST_IDLE            = 4'd0;
  localparam logic [StateW-1:0] ST_WAIT            = 4'd1;
  localparam logic [StateW-1:0] ST_CONFIRM_DETECT  = 4'd2;
  localparam logic [StateW-1:0] ST_FEEDER          = 4'd3;
  localparam logic [StateW-1:0] ST_INSERT          = 4'd4;
  localparam logic [StateW-1:0] ST_CRIMP_ON        = 4'd5;
  localparam logic [StateW-1:0] ST_CRIMP_OFF       = 4'd6;
  localparam logic [StateW-1:0] ST_VALVES_OFF      = 4'd7;
  localparam logic [StateW-1:0] ST_CONFIRM_REMOVAL = 4'd8;
  localparam logic [StateW-1:0] ST_REMOVED         = 4'd9;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SENSOR_LEVEL = 3'd0,
    CFG_CRIMP_EN     = 3'd1,
    CFG_CONFIRM      = 3'd2,
    CFG_INSERT_ON    = 3'd3,
    CFG_CRIMP_ON     = 3'd4,
    CFG_CRIMP_OFF    = 3'd5,
    CFG_INSERT_OFF   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic              sensor_active_level;
    logic              crimp_enable;
    logic [DelayW-1:0] confirm_time_ms;
    logic [DelayW-1:0] insert_on_delay_ms;
    logic [DelayW-1:0] crimp_on_delay_ms;
    logic [DelayW-1:0] crimp_off_delay_ms;
    logic [DelayW-1:0] insert_off_delay_ms;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    sensor_active_level: 1'b1,
    crimp_enable:        1'b1,
    confirm_time_ms:     16'd100,
    insert_on_delay_ms:  16'd100,
    crimp_on_delay_ms:   16'd100,
    crimp_off_delay_ms:  16'd100,
    insert_off_delay_ms: 16'd100
  };

  typedef struct packed {
    logic [StateW-1:0] state;
    logic [CntW-1:0]   time_in_state;
    logic              feeder_on;
    logic              insert_on;
    logic              crimp_on;
  } seq_t;

endpackage

/* src/csseq_if.sv */
// ----------------------------------------------------------------------------
// Crimp station sequencer channels
// Valid/ready channels for commands in and status results out.
// ----------------------------------------------------------------------------
interface csseq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       sensor_level;

  modport source (output valid, output kind, output sensor_level, input ready);
  modport sink   (input valid, input kind, input sensor_level, output ready);
endinterface

interface csseq_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] machine_state;
  logic       feeder_valve;
  logic       insert_valve;
  logic       crimp_valve;

  modport source (output valid, output machine_state, output feeder_valve,
                  output insert_valve, output crimp_valve, input ready);
  modport sink   (input valid, input machine_state, input feeder_valve,
                  input insert_valve, input crimp_valve, output ready);
endinterface

/* src/csseq_step.sv */
// ----------------------------------------------------------------------------
// Crimp station sequencer step logic
// Next sequencer record for one command: tick evaluation, start and stop.
// ----------------------------------------------------------------------------
module csseq_step (
  input  csseq_pkg::cfg_t  cfg_i,
  input  csseq_pkg::seq_t  cur_i,
  input  logic [1:0]       kind_i,
  input  logic             level_i,
  output csseq_pkg::seq_t  nxt_o
);
  import csseq_pkg::*;

  logic            present;
  logic [CntW-1:0] cnt_inc;

  function automatic logic waited(input logic [CntW-1:0] cnt,
                                  input logic [DelayW-1:0] dly);
    return cnt > {1'b0, dly};
  endfunction

  assign present = (level_i == cfg_i.sensor_active_level);
  assign cnt_inc = (cur_i.time_in_state != CntMax) ?
                   cur_i.time_in_state + CntW'(1) : cur_i.time_in_state;

  always_comb begin
    nxt_o = cur_i;
    unique case (kind_i)
      KIND_TICK: begin
        nxt_o.time_in_state = cnt_inc;
        unique case (cur_i.state)
          ST_IDLE: begin
            nxt_o.feeder_on = 1'b0;
            nxt_o.insert_on = 1'b0;
            nxt_o.crimp_on  = 1'b0;
          end
          ST_WAIT: begin
            if (present) begin
              nxt_o.state         = ST_CONFIRM_DETECT;
              nxt_o.time_in_state = '0;
            end
          end
          ST_CONFIRM_DETECT: begin
            if (!present) begin
              nxt_o.state         = ST_WAIT;
              nxt_o.time_in_state = '0;
            end else if (waited(cnt_inc, cfg_i.confirm_time_ms)) begin
              nxt_o.feeder_on     = 1'b1;
              nxt_o.state         = ST_FEEDER;
              nxt_o.time_in_state = '0;
            end
          end
          ST_FEEDER: begin
            if (waited(cnt_inc, cfg_i.insert_on_delay_ms)) begin
              nxt_o.insert_on     = 1'b1;
              nxt_o.state         = ST_INSERT;
              nxt_o.time_in_state = '0;
            end
          end
          ST_INSERT: begin
            if (waited(cnt_inc, cfg_i.crimp_on_delay_ms)) begin
              nxt_o.time_in_state = '0;
              if (cfg_i.crimp_enable) begin
                nxt_o.crimp_on = 1'b1;
                nxt_o.state    = ST_CRIMP_ON;
              end else begin
                // skip crimping and release the tube
                nxt_o.insert_on = 1'b0;
                nxt_o.feeder_on = 1'b0;
                nxt_o.state     = ST_VALVES_OFF;
              end
            end
          end
          ST_CRIMP_ON: begin
            if (waited(cnt_inc, cfg_i.crimp_off_delay_ms)) begin
              nxt_o.crimp_on      = 1'b0;
              nxt_o.state         = ST_CRIMP_OFF;
              nxt_o.time_in_state = '0;
            end
          end
          ST_CRIMP_OFF: begin
            if (waited(cnt_inc, cfg_i.insert_off_delay_ms)) begin
              nxt_o.insert_on     = 1'b0;
              nxt_o.feeder_on     = 1'b0;
              nxt_o.state         = ST_VALVES_OFF;
              nxt_o.time_in_state = '0;
            end
          end
          ST_VALVES_OFF: begin
            if (!present) begin
              nxt_o.state         = ST_CONFIRM_REMOVAL;
              nxt_o.time_in_state = '0;
            end
          end
          ST_CONFIRM_REMOVAL: begin
            // tube back: restart the removal timer
            if (present) begin
              nxt_o.time_in_state = '0;
            end else if (waited(cnt_inc, cfg_i.confirm_time_ms)) begin
              nxt_o.state         = ST_REMOVED;
              nxt_o.time_in_state = '0;
            end
          end
          default: begin
            nxt_o.state         = ST_WAIT;
            nxt_o.time_in_state = '0;
          end
        endcase
      end
      KIND_START: begin
        nxt_o.state         = ST_WAIT;
        nxt_o.time_in_state = '0;
      end
      KIND_STOP: begin
        nxt_o.state         = ST_IDLE;
        nxt_o.time_in_state = '0;
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

/* src/crimp_station_sequencer.sv */
// ----------------------------------------------------------------------------
// Crimp station sequencer
// Ten-state pneumatic crimp sequencer driven by tick, start and stop commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one command per transaction: a 1 ms tick with the raw sensor
//   level, a start or a stop. out_o returns exactly one status transaction per
//   command: the state and the feeder, insert and crimp valve drives after it.
//   Each command is evaluated in the cycle it is accepted and its status is
//   registered, so the status is offered in the cycle after acceptance. One
//   command per cycle is taken back to back while the receiver keeps up; the
//   single status register sets that rate. in_i is ready whenever the status
//   register is empty or its content is being taken in the same cycle, so a
//   stalled receiver stalls the command side after one transaction. The user
//   writes registers via cfg_we_i/cfg_idx_i/cfg_wdata_i only while no command
//   is in flight (not enforced by the block); an index beyond the register
//   list is ignored. Reset puts the sequencer in idle with a cleared timer and
//   all valves off, loads register defaults and empties the status register.
// ----------------------------------------------------------------------------
module crimp_station_sequencer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [csseq_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [csseq_pkg::CfgDataW-1:0]     cfg_wdata_i,
  csseq_in_if.sink                           in_i,
  csseq_out_if.source                        out_o
);
  import csseq_pkg::*;

  cfg_t cfg_q;
  seq_t seq_q, seq_d;
  logic out_valid_q;
  logic [StateW-1:0] out_state_q;
  logic out_feeder_q, out_insert_q, out_crimp_q;
  logic in_acc;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SENSOR_LEVEL: cfg_q.sensor_active_level <= cfg_wdata_i[0];
        CFG_CRIMP_EN:     cfg_q.crimp_enable        <= cfg_wdata_i[0];
        CFG_CONFIRM:      cfg_q.confirm_time_ms     <= cfg_wdata_i;
        CFG_INSERT_ON:    cfg_q.insert_on_delay_ms  <= cfg_wdata_i;
        CFG_CRIMP_ON:     cfg_q.crimp_on_delay_ms   <= cfg_wdata_i;
        CFG_CRIMP_OFF:    cfg_q.crimp_off_delay_ms  <= cfg_wdata_i;
        CFG_INSERT_OFF:   cfg_q.insert_off_delay_ms <= cfg_wdata_i;
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  csseq_step u_step (
    .cfg_i   (cfg_q),
    .cur_i   (seq_q),
    .kind_i  (in_i.kind),
    .level_i (in_i.sensor_level),
    .nxt_o   (seq_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '{state: ST_IDLE, time_in_state: '0,
                 feeder_on: 1'b0, insert_on: 1'b0, crimp_on: 1'b0};
    end else if (in_acc) begin
      seq_q <= seq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // status payload: load on every accepted command
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_state_q  <= seq_d.state;
      out_feeder_q <= seq_d.feeder_on;
      out_insert_q <= seq_d.insert_on;
      out_crimp_q  <= seq_d.crimp_on;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.machine_state = out_state_q;
  assign out_o.feeder_valve  = out_feeder_q;
  assign out_o.insert_valve  = out_insert_q;
  assign out_o.crimp_valve   = out_crimp_q;

endmodule

/* src/csseq_checker.sv */
// ----------------------------------------------------------------------------
// Crimp station sequencer checker
// Port-level properties of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module csseq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_kind,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_state
);
  import csseq_pkg::*;

  // every accepted command yields a status in the next cycle
  a_acc_gives_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted command produced no status");

  // an empty status register never blocks commands
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("command side stalled with empty status register");

  // start always lands in wait
  a_start_to_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready && in_kind == KIND_START) |=> out_state == ST_WAIT)
    else $error("start did not move to wait");

  // a stalled status holds its state
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_state)))
    else $error("stalled status changed");

endmodule

bind crimp_station_sequencer csseq_checker u_csseq_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_kind   (in_i.kind),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_state (out_o.machine_state)
);
